// ----- hw/rtl/qcf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcf_pkg
// Shared constants of the quadratic curve flattener.
// ----------------------------------------------------------------------------
package qcf_pkg;

    localparam int unsigned THRESH_BITS = 8;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 8'd5;

endpackage
`default_nettype wire

// ----- hw/rtl/qcf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcf_front
// Input side: takes curves and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module qcf_front #(
    parameter int unsigned COORD_BITS = 12
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [COORD_BITS*6-1:0] i_curve,
    output logic                         o_q_valid,
    input  wire logic                    i_q_pop,
    output logic [COORD_BITS*6-1:0]      o_q_curve
);

    logic [COORD_BITS*6-1:0] r_mem [2];
    logic                    r_wr_ptr;
    logic                    n_wr_ptr;
    logic                    r_rd_ptr;
    logic                    n_rd_ptr;
    logic [1:0]              r_count;
    logic [1:0]              n_count;
    logic                    push;
    logic                    pop;

    assign o_in_ready = (r_count != 2'd2);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_curve  = r_mem[r_rd_ptr];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_q_pop && o_q_valid;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_curve;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2 && !pop) |=> (r_count == 2'd2))
        else $error("queue full count changed without a read");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/qcf_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcf_engine
// Subdivision engine: splits the current half or emits it as a segment,
// keeping pending right halves on a small stack.
// ----------------------------------------------------------------------------
module qcf_engine #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned MAX_DEPTH  = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [qcf_pkg::THRESH_BITS-1:0] i_flat_threshold,
    input  wire logic                          i_q_valid,
    output logic                               o_q_pop,
    input  wire logic [COORD_BITS*6-1:0]       i_q_curve,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [COORD_BITS-1:0]              o_seg_from_x,
    output logic [COORD_BITS-1:0]              o_seg_from_y,
    output logic [COORD_BITS-1:0]              o_seg_to_x,
    output logic [COORD_BITS-1:0]              o_seg_to_y,
    output logic                               o_last
);

    localparam int unsigned C   = COORD_BITS;
    localparam int unsigned LW  = $clog2(MAX_DEPTH + 1);
    localparam int unsigned IW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [LW-1:0] LVL_MAX = LW'(MAX_DEPTH);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    function automatic logic [C-1:0] mid(input logic [C-1:0] a, input logic [C-1:0] b);
        logic [C:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[C:1];
    endfunction

    function automatic logic [C-1:0] absdiff(input logic [C-1:0] a, input logic [C-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    t_state         r_state;
    logic [C-1:0]   r_sx, r_sy, r_cx, r_cy, r_ex, r_ey;
    logic [LW-1:0]  r_lvl;
    logic [LW-1:0]  r_sp;

    logic [2*C-1:0] r_stk_pt  [MAX_DEPTH];
    logic [4*C-1:0] r_stk_ce  [MAX_DEPTH];
    logic [LW-1:0]  r_stk_lvl [MAX_DEPTH];

    logic [C-1:0]   ax, ay, qx, qy, bx, by, mx, my;
    logic [C:0]     flat_dist;
    logic           do_split;
    logic           out_free;
    logic           emit;
    logic [IW-1:0]  wr_idx;
    logic [IW-1:0]  rd_idx;
    logic [LW-1:0]  sp_dec;

    assign ax = mid(r_sx, r_cx);
    assign ay = mid(r_sy, r_cy);
    assign qx = mid(r_cx, r_ex);
    assign qy = mid(r_cy, r_ey);
    assign bx = mid(ax, qx);
    assign by = mid(ay, qy);

    // flatness: control point against the chord midpoint
    assign mx        = mid(r_sx, r_ex);
    assign my        = mid(r_sy, r_ey);
    assign flat_dist = {1'b0, absdiff(r_cx, mx)} + {1'b0, absdiff(r_cy, my)};

    // the whole curve is always split once
    assign do_split = (r_lvl == '0) ||
                      ((r_lvl < LVL_MAX) &&
                       (flat_dist > (C+1)'(i_flat_threshold)));
    assign out_free = !o_out_valid || i_out_ready;
    assign emit     = (r_state == S_RUN) && !do_split && out_free;
    assign sp_dec   = r_sp - LW'(1);
    assign wr_idx   = r_sp[IW-1:0];
    assign rd_idx   = sp_dec[IW-1:0];
    assign o_q_pop  = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_lvl       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        {r_sx, r_sy, r_cx, r_cy, r_ex, r_ey} <= i_q_curve;
                        r_lvl   <= '0;
                        r_sp    <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (do_split) begin
                        r_cx  <= ax;
                        r_cy  <= ay;
                        r_ex  <= bx;
                        r_ey  <= by;
                        r_lvl <= r_lvl + LW'(1);
                        r_sp  <= r_sp + LW'(1);
                    end else if (out_free) begin
                        o_out_valid  <= 1'b1;
                        o_seg_from_x <= r_sx;
                        o_seg_from_y <= r_sy;
                        o_seg_to_x   <= r_ex;
                        o_seg_to_y   <= r_ey;
                        o_last       <= (r_sp == '0);
                        if (r_sp == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            {r_sx, r_sy} <= r_stk_pt[rd_idx];
                            {r_cx, r_cy, r_ex, r_ey} <= r_stk_ce[rd_idx];
                            r_lvl <= r_stk_lvl[rd_idx];
                            r_sp  <= sp_dec;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // stack of pending right halves
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN && do_split) begin
            r_stk_pt[wr_idx]  <= {bx, by};
            r_stk_ce[wr_idx]  <= {qx, qy, r_ex, r_ey};
            r_stk_lvl[wr_idx] <= r_lvl + LW'(1);
        end
    end

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= LVL_MAX)
        else $error("stack pointer beyond depth");
    a_lvl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_lvl <= LVL_MAX && r_sp <= r_lvl))
        else $error("level or stack depth inconsistent");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_sp == '0) |=> (r_state == S_IDLE && o_out_valid && o_last))
        else $error("last segment did not end the curve");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_seg_to_x)))
        else $error("stalled segment changed");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/quadratic_curve_flattener_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_curve_flattener_core
// Flattens quadratic curves into line segments by midpoint subdivision.
// ----------------------------------------------------------------------------
// Each curve taken on the input channel is split depth first, left half
// before right, until a half is within flat_threshold (Manhattan distance of
// the control point from the chord midpoint) or reaches MAX_DEPTH; every such
// half leaves as one segment, and the final one carries o_last. The engine
// loads a curve from the queue while idle, then makes one split per cycle,
// or emits one segment per cycle while the output is not stalled, in the
// single split/emit step of the engine. A two-entry queue in front lets new
// curves be taken while the engine works, and a stalled output only holds the
// engine when it has a segment to send.
// flat_threshold resets to 5 and is written through i_cfg_wr_en.
module quadratic_curve_flattener_core #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned MAX_DEPTH  = 6
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [qcf_pkg::THRESH_BITS-1:0] i_cfg_wr_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [COORD_BITS-1:0]           i_start_x,
    input  wire logic [COORD_BITS-1:0]           i_start_y,
    input  wire logic [COORD_BITS-1:0]           i_ctrl_x,
    input  wire logic [COORD_BITS-1:0]           i_ctrl_y,
    input  wire logic [COORD_BITS-1:0]           i_end_x,
    input  wire logic [COORD_BITS-1:0]           i_end_y,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [COORD_BITS-1:0]                o_seg_from_x,
    output logic [COORD_BITS-1:0]                o_seg_from_y,
    output logic [COORD_BITS-1:0]                o_seg_to_x,
    output logic [COORD_BITS-1:0]                o_seg_to_y,
    output logic                                 o_last
);

    logic [qcf_pkg::THRESH_BITS-1:0] r_flat_threshold;
    logic                            q_valid;
    logic                            q_pop;
    logic [COORD_BITS*6-1:0]         q_curve;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flat_threshold <= qcf_pkg::THRESH_RESET;
        end else if (i_cfg_wr_en) begin
            r_flat_threshold <= i_cfg_wr_data;
        end
    end

    qcf_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_curve    ({i_start_x, i_start_y, i_ctrl_x, i_ctrl_y, i_end_x, i_end_y}),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_curve  (q_curve)
    );

    qcf_engine #(
        .COORD_BITS (COORD_BITS),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_flat_threshold (r_flat_threshold),
        .i_q_valid        (q_valid),
        .o_q_pop          (q_pop),
        .i_q_curve        (q_curve),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_seg_from_x     (o_seg_from_x),
        .o_seg_from_y     (o_seg_from_y),
        .o_seg_to_x       (o_seg_to_x),
        .o_seg_to_y       (o_seg_to_y),
        .o_last           (o_last)
    );

endmodule
`default_nettype wire
